@@ sv/assert_macros.svh @@
// Assertion macros used by the core RTL file of the gravity force block.
// No dependencies; take in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is low
`define SGPF_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset
`define SGPF_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/sgpf_pkg.sv @@
// Shared widths, constants and types of the softened pair gravity force block.
// No dependencies.
package sgpf_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Field widths
    localparam int POS_W   = 32;
    localparam int MASS_W  = 32;
    localparam int CFG_W   = 32;
    localparam int FORCE_W = 48;

    // Datapath widths
    localparam int HALF_W  = 32;
    localparam int DIFF_W  = POS_W + 1;
    localparam int MAG_W   = 32;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int MM_W    = 2 * MASS_W;
    localparam int GMM_W   = 64;
    localparam int NUM_W   = GMM_W + MAG_W;
    localparam int QUO_W   = FORCE_W;
    localparam int DIV_LAT = QUO_W + 2;
    localparam int AXES    = 3;

    // Register reset values
    localparam logic [CFG_W-1:0] GRAVITY_RST = 32'd286649554;
    localparam logic [CFG_W-1:0] SOFTEN_RST  = 32'd66;

    // Register indexes
    localparam logic REG_GRAVITY = 1'b0;
    localparam logic REG_SOFTEN  = 1'b1;

    // Saturation limits
    localparam logic [FORCE_W-1:0] FORCE_POS_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic [FORCE_W-1:0] FORCE_NEG_MAX = {1'b1, {(FORCE_W-1){1'b0}}};

    // Per-axis numerators and signs carried past the root pipeline
    typedef struct packed {
        logic [AXES-1:0][NUM_W-1:0] num;
        logic [AXES-1:0]            neg;
    } t_side;

endpackage

@@ sv/softened_pair_gravity_force_core.sv @@
// Softened pair gravity force: F = G*mA*mB*(B-A)/(r^3+eps) per axis, saturated.
// Stages: 5 front stages, 33 root stages, 4 cube stages, 50 divider stages and
// the output register. Throughput one pair per cycle; a stalled output holds
// the whole pipeline. Synchronous active-low reset clears all valid bits and
// loads the register defaults. Depends on sgpf_pkg and the sgpf_* submodules.
`include "assert_macros.svh"

module softened_pair_gravity_force_core #(
    parameter int FRAC_BITS = sgpf_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [sgpf_pkg::CFG_W-1:0]          i_cfg_data,
    // pair input
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [sgpf_pkg::POS_W-1:0]   i_a_x,
    input  logic signed [sgpf_pkg::POS_W-1:0]   i_a_y,
    input  logic signed [sgpf_pkg::POS_W-1:0]   i_a_z,
    input  logic [sgpf_pkg::MASS_W-1:0]         i_a_mass,
    input  logic signed [sgpf_pkg::POS_W-1:0]   i_b_x,
    input  logic signed [sgpf_pkg::POS_W-1:0]   i_b_y,
    input  logic signed [sgpf_pkg::POS_W-1:0]   i_b_z,
    input  logic [sgpf_pkg::MASS_W-1:0]         i_b_mass,
    // force output
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [sgpf_pkg::FORCE_W-1:0] o_force_x,
    output logic signed [sgpf_pkg::FORCE_W-1:0] o_force_y,
    output logic signed [sgpf_pkg::FORCE_W-1:0] o_force_z,
    output logic                                o_overflow
);
    import sgpf_pkg::*;

    localparam int R2_W       = 2 * ROOT_W - FRAC_BITS;
    localparam int PL_W       = HALF_W + ROOT_W;
    localparam int PH_W       = R2_W - HALF_W + ROOT_W;
    localparam int R3P_W      = R2_W + ROOT_W;
    localparam int DEN_W      = R3P_W - FRAC_BITS + 1;
    localparam int DV_W       = DEN_W + FRAC_BITS;
    localparam int SIDE_DEPTH = ROOT_W + 4;
    localparam int VLD_DEPTH  = SIDE_DEPTH + DIV_LAT;

    logic w_adv;

    // Move every stage unless a finished result is waiting and the output is not ready
    assign w_adv      = !o_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] r_grav;
    logic [CFG_W-1:0] r_soft;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= GRAVITY_RST;
            r_soft <= SOFTEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GRAVITY: r_grav <= i_cfg_data;
                REG_SOFTEN:  r_soft <= i_cfg_data;
            endcase
        end
    end

    // ---------------- valid bits ----------------
    logic                 r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;
    logic [VLD_DEPTH-1:0] r_vld_line;
    logic                 r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld     <= 1'b0;
            r2_vld     <= 1'b0;
            r3_vld     <= 1'b0;
            r4_vld     <= 1'b0;
            r5_vld     <= 1'b0;
            r_vld_line <= '0;
            r_out_vld  <= 1'b0;
        end else if (w_adv) begin
            r1_vld     <= i_in_valid;
            r2_vld     <= r1_vld;
            r3_vld     <= r2_vld;
            r4_vld     <= r3_vld;
            r5_vld     <= r4_vld;
            r_vld_line <= {r_vld_line[VLD_DEPTH-2:0], r5_vld};
            r_out_vld  <= r_vld_line[VLD_DEPTH-1];
        end
    end

    // ---------------- front stages ----------------
    logic [POS_W-1:0]  w_a [AXES];
    logic [POS_W-1:0]  w_b [AXES];

    assign w_a[0] = i_a_x;
    assign w_a[1] = i_a_y;
    assign w_a[2] = i_a_z;
    assign w_b[0] = i_b_x;
    assign w_b[1] = i_b_y;
    assign w_b[2] = i_b_z;

    logic [DIFF_W-1:0] r1_d [AXES];
    logic [MM_W-1:0]   r1_mm;
    logic [MAG_W-1:0]  r2_mag [AXES];
    logic [AXES-1:0]   r2_neg;
    logic [MM_W-1:0]   r2_gm_lo;
    logic [MM_W-1:0]   r2_gm_hi;
    logic [SQ_W-1:0]   r3_sq [AXES];
    logic [MAG_W-1:0]  r3_mag [AXES];
    logic [AXES-1:0]   r3_neg;
    logic [GMM_W-1:0]  r3_gmm;
    logic [SUM_W-1:0]  r4_sum;
    logic [SQ_W-1:0]   r4_nl [AXES];
    logic [SQ_W-1:0]   r4_nh [AXES];
    logic [AXES-1:0]   r4_neg;
    logic [SUM_W-1:0]  r5_sum;
    t_side             r5_side;

    logic [DIFF_W-1:0] w_abs [AXES];

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            w_abs[i] = r1_d[i][DIFF_W-1] ? (DIFF_W'(0) - r1_d[i]) : r1_d[i];
        end
    end

    // Displacement, squares, G*mA*mB and the per-axis numerators
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < AXES; i++) begin
                r1_d[i]   <= {w_b[i][POS_W-1], w_b[i]} - {w_a[i][POS_W-1], w_a[i]};
                r2_mag[i] <= w_abs[i][MAG_W-1:0];
                r2_neg[i] <= r1_d[i][DIFF_W-1];
                r3_sq[i]  <= r2_mag[i] * r2_mag[i];
                r3_mag[i] <= r2_mag[i];
                r4_nl[i]  <= r3_gmm[HALF_W-1:0] * r3_mag[i];
                r4_nh[i]  <= r3_gmm[GMM_W-1:HALF_W] * r3_mag[i];
                r5_side.num[i] <= {r4_nh[i], {HALF_W{1'b0}}} + NUM_W'(r4_nl[i]);
            end
            r1_mm          <= i_a_mass * i_b_mass;
            r2_gm_lo       <= r1_mm[HALF_W-1:0] * r_grav;
            r2_gm_hi       <= r1_mm[MM_W-1:HALF_W] * r_grav;
            r3_gmm         <= r2_gm_hi + GMM_W'(r2_gm_lo[MM_W-1:HALF_W]);
            r3_neg         <= r2_neg;
            r4_sum         <= SUM_W'(r3_sq[0]) + SUM_W'(r3_sq[1]) + SUM_W'(r3_sq[2]);
            r4_neg         <= r3_neg;
            r5_sum         <= r4_sum;
            r5_side.neg    <= r4_neg;
        end
    end

    // ---------------- distance root and side data ----------------
    logic [ROOT_W-1:0] w_root;
    t_side             w_side;

    sgpf_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_sum  (r5_sum),
        .o_root (w_root)
    );

    sgpf_delay #(
        .W     ($bits(t_side)),
        .DEPTH (SIDE_DEPTH)
    ) u_side_dly (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_d   (r5_side),
        .o_q   (w_side)
    );

    // ---------------- cube and softening ----------------
    logic [SUM_W-1:0]  r_a_rr;
    logic [ROOT_W-1:0] r_a_root;
    logic [PL_W-1:0]   r_b_pl;
    logic [PH_W-1:0]   r_b_ph;
    logic [R3P_W-1:0]  r_c_r3;
    logic [DEN_W-1:0]  r_d_den;
    logic [R2_W-1:0]   w_r2;

    assign w_r2 = r_a_rr[SUM_W-1:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_rr   <= w_root * w_root;
            r_a_root <= w_root;
            r_b_pl   <= w_r2[HALF_W-1:0] * r_a_root;
            r_b_ph   <= w_r2[R2_W-1:HALF_W] * r_a_root;
            r_c_r3   <= (R3P_W'(r_b_ph) << HALF_W) + R3P_W'(r_b_pl);
            r_d_den  <= DEN_W'(r_c_r3[R3P_W-1:FRAC_BITS]) + DEN_W'(r_soft);
        end
    end

    // ---------------- per-axis division ----------------
    logic [FORCE_W-1:0] w_mag [AXES];
    logic [AXES-1:0]    w_neg;
    logic [AXES-1:0]    w_ovf;

    for (genvar g = 0; g < AXES; g++) begin : g_axis
        sgpf_div #(
            .DV_W (DV_W)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_num (w_side.num[g]),
            .i_dv  ({r_d_den, {FRAC_BITS{1'b0}}}),
            .i_neg (w_side.neg[g]),
            .o_mag (w_mag[g]),
            .o_neg (w_neg[g]),
            .o_ovf (w_ovf[g])
        );
    end

    // ---------------- output register ----------------
    logic [FORCE_W-1:0] r_out_force [AXES];
    logic               r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < AXES; i++) begin
                r_out_force[i] <= w_neg[i] ? (FORCE_W'(0) - w_mag[i]) : w_mag[i];
            end
            r_out_ovf <= |w_ovf;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_force_x   = r_out_force[0];
    assign o_force_y   = r_out_force[1];
    assign o_force_z   = r_out_force[2];
    assign o_overflow  = r_out_ovf;

    // ---------------- assertions ----------------
    `SGPF_ASSERT(a_ovf_means_clamp, i_clk, i_rst_n, o_out_valid && o_overflow |-> (o_force_x == FORCE_POS_MAX || o_force_x == FORCE_NEG_MAX || o_force_y == FORCE_POS_MAX || o_force_y == FORCE_NEG_MAX || o_force_z == FORCE_POS_MAX || o_force_z == FORCE_NEG_MAX), "overflow set without a clamped component")
    `SGPF_ASSERT_ALWAYS(a_rst_empties, i_clk, !i_rst_n |=> !o_out_valid, "result valid right after reset")
    `SGPF_ASSERT(a_ready_only_on_stall, i_clk, i_rst_n, !o_in_ready |-> o_out_valid && !i_out_ready, "input stalled without a waiting result")

endmodule

@@ sv/sgpf_delay.sv @@
// Enable-gated shift line that carries data alongside a pipeline.
// Depends on nothing; width and depth come from parameters.
module sgpf_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_line [DEPTH];

    // Advance the line on each enabled cycle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_q = r_line[DEPTH-1];

endmodule

@@ sv/sgpf_isqrt.sv @@
// Pipelined integer square root, one root bit per stage.
// Depends on sgpf_pkg for widths.
module sgpf_isqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [sgpf_pkg::SUM_W-1:0]  i_sum,
    output logic [sgpf_pkg::ROOT_W-1:0] o_root
);
    import sgpf_pkg::*;

    logic [SUM_W-1:0]  r_rem [ROOT_W];
    logic [ROOT_W-1:0] r_y   [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int B = ROOT_W - 1 - k;
        logic [SUM_W-1:0]  w_rem_in;
        logic [ROOT_W-1:0] w_y_in;
        logic [SUM_W-1:0]  w_trial;
        logic [SUM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_y;

        if (k == 0) begin : g_first
            assign w_rem_in = i_sum;
            assign w_y_in   = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_y_in   = r_y[k-1];
        end

        // Try setting bit B: (y + 2^B)^2 - y^2 = y*2^(B+1) + 2^(2B)
        always_comb begin
            w_trial = (SUM_W'(w_y_in) << (B + 1)) | (SUM_W'(1) << (2 * B));
            n_rem   = w_rem_in;
            n_y     = w_y_in;
            if (w_rem_in >= w_trial) begin
                n_rem = w_rem_in - w_trial;
                n_y   = w_y_in | (ROOT_W'(1) << B);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_y[k]   <= n_y;
            end
        end
    end

    assign o_root = r_y[ROOT_W-1];

endmodule

@@ sv/sgpf_div.sv @@
// Pipelined restoring divider giving a saturated force magnitude, one bit a stage.
// Depends on sgpf_pkg for widths and limits.
module sgpf_div #(
    parameter int DV_W = 84
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [sgpf_pkg::NUM_W-1:0]   i_num,
    input  logic [DV_W-1:0]              i_dv,
    input  logic                         i_neg,
    output logic [sgpf_pkg::FORCE_W-1:0] o_mag,
    output logic                         o_neg,
    output logic                         o_ovf
);
    import sgpf_pkg::*;

    // Index 0 is the setup stage, index j+1 the stage that makes quotient bit QUO_W-1-j
    logic [DV_W-1:0]  r_p    [QUO_W+1];
    logic [DV_W-1:0]  r_dv   [QUO_W+1];
    logic [NUM_W-1:0] r_num  [QUO_W+1];
    logic [QUO_W-1:0] r_q    [QUO_W+1];
    logic             r_neg  [QUO_W+1];
    logic             r_sat  [QUO_W+1];
    logic             r_zero [QUO_W+1];

    logic [FORCE_W-1:0] r_mag;
    logic               r_neg_o;
    logic               r_ovf;

    logic [QUO_W-1:0] w_hi;
    assign w_hi = i_num[NUM_W-1:NUM_W-QUO_W];

    // Set up: a quotient of 2^QUO_W or more saturates, as does any nonzero over zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0]    <= DV_W'(w_hi);
            r_dv[0]   <= i_dv;
            r_num[0]  <= i_num;
            r_q[0]    <= '0;
            r_neg[0]  <= i_neg;
            r_sat[0]  <= (DV_W'(w_hi) >= i_dv);
            r_zero[0] <= (i_num == '0);
        end
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        localparam int I = QUO_W - 1 - j;
        logic [DV_W:0]    w_t;
        logic [DV_W:0]    w_diff;
        logic             w_ge;
        logic [DV_W-1:0]  n_p;
        logic [QUO_W-1:0] n_q;

        // Shift in the next numerator bit and subtract where it fits
        always_comb begin
            w_t    = {r_p[j], r_num[j][I]};
            w_diff = w_t - {1'b0, r_dv[j]};
            w_ge   = (w_t >= {1'b0, r_dv[j]});
            n_p    = w_ge ? w_diff[DV_W-1:0] : w_t[DV_W-1:0];
            n_q    = r_q[j];
            n_q[I] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[j+1]    <= n_p;
                r_dv[j+1]   <= r_dv[j];
                r_num[j+1]  <= r_num[j];
                r_q[j+1]    <= n_q;
                r_neg[j+1]  <= r_neg[j];
                r_sat[j+1]  <= r_sat[j];
                r_zero[j+1] <= r_zero[j];
            end
        end
    end

    // Clamp to the limit of the result sign
    logic [FORCE_W-1:0] w_lim;
    logic [FORCE_W-1:0] n_mag;
    logic               n_ovf;

    always_comb begin
        w_lim = FORCE_POS_MAX + FORCE_W'(r_neg[QUO_W]);
        n_mag = r_q[QUO_W];
        n_ovf = 1'b0;
        if (r_zero[QUO_W]) begin
            n_mag = '0;
        end else if (r_sat[QUO_W] || (r_q[QUO_W] > w_lim)) begin
            n_mag = w_lim;
            n_ovf = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag   <= n_mag;
            r_neg_o <= r_neg[QUO_W];
            r_ovf   <= n_ovf;
        end
    end

    assign o_mag = r_mag;
    assign o_neg = r_neg_o;
    assign o_ovf = r_ovf;

endmodule
